// ===== rtl/motor_speed_pid_step_assert.svh =====
// Assertion macros for the motor speed PID tick block.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
`ifndef MOTOR_SPEED_PID_STEP_ASSERT_SVH
`define MOTOR_SPEED_PID_STEP_ASSERT_SVH

// Same-cycle implication.
`define MSPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/msps_pkg.sv =====
package msps_pkg;

  localparam int MSPS_MOTOR_COUNT = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_INT_LIMIT   = 3'd3,
    CFG_SPEED_SCALE = 3'd4
  } msps_cfg_t;

  localparam logic signed [15:0] RST_GAIN_P      = 16'sd256;
  localparam logic signed [15:0] RST_GAIN_I      = 16'sd0;
  localparam logic signed [15:0] RST_GAIN_D      = 16'sd0;
  localparam logic [14:0]        RST_INT_LIMIT   = 15'd150;
  localparam logic [7:0]         RST_SPEED_SCALE = 8'd75;

  // Restoring divider: one quotient bit per step over the 40-bit product.
  localparam int DIV_STEPS = 40;
  localparam int DIV_CNT_W = 6;

  // Subtract passes needed to wrap a 2-bit channel number.
  localparam int WRAP_STEPS = 3;

  localparam logic [7:0] DRIVE_MAX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SPD,
    ST_ERR,
    ST_SUM,
    ST_GAIN,
    ST_FIN
  } msps_state_t;

endpackage

// ===== rtl/motor_speed_pid_step.sv =====
// Speed PID tick for MOTOR_COUNT motor channels, one item at a time.
// The 40-step restoring divider (one quotient bit per cycle) takes most of
// each item's time. A new item is accepted only after the previous one is
// in the output register; a stalled result side holds new items off.
// Reset (rst_n low, synchronous): sequencer idle, no result pending, gains,
// limit and scale at their defaults, per-channel sum, error and target zero.
module motor_speed_pid_step
  import msps_pkg::*;
#(
  parameter int MOTOR_COUNT = MSPS_MOTOR_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_motor_index,
  input  logic signed [15:0]    in_target_speed,
  input  logic signed [31:0]    in_pulse_count,
  input  logic [31:0]           in_elapsed_time,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [8:0]     out_drive_level,
  output logic signed [15:0]    out_measured_speed,
  output logic signed [15:0]    out_speed_error,
  output logic                  out_divide_fault
);

  localparam int CH_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int WRAP_W = 5;

  // ---------------------------------------------------------------------
  // Shared configuration registers
  // ---------------------------------------------------------------------
  logic signed [15:0] gain_p_r;
  logic signed [15:0] gain_i_r;
  logic signed [15:0] gain_d_r;
  logic [14:0]        lim_r;
  logic [7:0]         scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= RST_GAIN_P;
      gain_i_r <= RST_GAIN_I;
      gain_d_r <= RST_GAIN_D;
      lim_r    <= RST_INT_LIMIT;
      scale_r  <= RST_SPEED_SCALE;
    end else if (cfg_we) begin
      case (msps_cfg_t'(cfg_index))
        CFG_GAIN_P:      gain_p_r <= cfg_data;
        CFG_GAIN_I:      gain_i_r <= cfg_data;
        CFG_GAIN_D:      gain_d_r <= cfg_data;
        CFG_INT_LIMIT:   lim_r    <= cfg_data[14:0];
        CFG_SPEED_SCALE: scale_r  <= cfg_data[7:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  msps_state_t state_r, state_nxt;

  logic                 in_acc;
  logic                 load_out;
  logic                 out_valid_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [1:0]           gcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_SPD;
      end
      ST_SPD: state_nxt = ST_ERR;
      ST_ERR: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_GAIN;
      ST_GAIN: begin
        if (gcnt_r == 2'd3) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold the finished item until the output register frees up
        load_out = !out_valid_r || !out_stall;
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Channel wrap: motor_index modulo MOTOR_COUNT by repeated subtraction
  // ---------------------------------------------------------------------
  logic [WRAP_W-1:0] wrap_idx;

  always_comb begin
    wrap_idx = WRAP_W'(in_motor_index);
    for (int k = 0; k < WRAP_STEPS; k++) begin
      if (wrap_idx >= WRAP_W'(MOTOR_COUNT)) wrap_idx = wrap_idx - WRAP_W'(MOTOR_COUNT);
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  logic [CH_W-1:0]    ch_r;
  logic signed [15:0] tgt_r;
  logic               neg_r;
  logic               fault_r;
  logic [31:0]        pmag_r;
  logic [31:0]        div_r;
  logic [39:0]        quo_r;
  logic [31:0]        rem_r;
  logic signed [15:0] speed_r;
  logic signed [15:0] err_r;
  logic [14:0]        sum_r;
  logic signed [16:0] diff_r;
  logic signed [32:0] prod_r;
  logic signed [34:0] acc_r;

  // per-channel controller state
  logic [14:0]        int_sum_r  [MOTOR_COUNT];
  logic signed [15:0] prev_err_r [MOTOR_COUNT];
  logic signed [15:0] prev_tgt_r [MOTOR_COUNT];

  // magnitude of the pulse count; the most negative count maps to 2^31
  logic [31:0] pmag_in;
  assign pmag_in = in_pulse_count[31] ? (~in_pulse_count + 32'd1) : in_pulse_count;

  // pulses * scale, unsigned magnitude, fits 40 bits
  logic [39:0] spd_prod;
  assign spd_prod = pmag_r * scale_r;

  // one restoring divide step
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        q_bit;
  logic [31:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[39]};
    rem_sub = rem_sh - {1'b0, div_r};
    q_bit   = !rem_sub[32];
    rem_nxt = q_bit ? rem_sub[31:0] : rem_sh[31:0];
  end

  // saturate the quotient into a signed 16-bit speed; zero time forces 0
  logic signed [15:0] speed_nxt;

  always_comb begin
    if (fault_r) begin
      speed_nxt = 16'sd0;
    end else if (neg_r) begin
      if (quo_r > 40'd32768) speed_nxt = -16'sd32768;
      else                   speed_nxt = -$signed(quo_r[15:0]);
    end else begin
      if (quo_r > 40'd32767) speed_nxt = 16'sd32767;
      else                   speed_nxt = $signed(quo_r[15:0]);
    end
  end

  // saturated speed error
  logic signed [16:0] err_wide;
  logic signed [15:0] err_nxt;

  always_comb begin
    err_wide = 17'(tgt_r) - 17'(speed_r);
    if (err_wide > 17'sd32767)       err_nxt = 16'sd32767;
    else if (err_wide < -17'sd32768) err_nxt = -16'sd32768;
    else                             err_nxt = err_wide[15:0];
  end

  // integral update and derivative difference for the current channel
  logic [15:0]        abs_e;
  logic [14:0]        sum_base;
  logic [16:0]        sum_wide;
  logic [14:0]        sum_nxt;
  logic signed [16:0] diff_nxt;

  always_comb begin
    abs_e    = err_r[15] ? (~err_r + 16'd1) : err_r;
    // a new target restarts the integral
    sum_base = (tgt_r != prev_tgt_r[ch_r]) ? 15'd0 : int_sum_r[ch_r];
    sum_wide = 17'(sum_base) + 17'(abs_e);
    sum_nxt  = (sum_wide > 17'(lim_r)) ? lim_r : sum_wide[14:0];
    diff_nxt = 17'(err_r) - 17'(prev_err_r[ch_r]);
  end

  // shared gain multiplier: Kp*e, then Ki*sum, then Kd*diff
  logic signed [15:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [32:0] mul_p;

  always_comb begin
    case (gcnt_r)
      2'd0: begin
        mul_a = gain_p_r;
        mul_b = 17'(err_r);
      end
      2'd1: begin
        mul_a = gain_i_r;
        mul_b = $signed({2'b00, sum_r});
      end
      2'd2: begin
        mul_a = gain_d_r;
        mul_b = diff_r;
      end
      default: begin
        mul_a = 16'sd0;
        mul_b = 17'sd0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Q27.8 accumulator (35 bits, 8 fraction bits) to drive magnitude, then apply the error's sign
  logic signed [34:0] acc_sh;
  logic [7:0]         mag;
  logic signed [8:0]  drive_nxt;

  always_comb begin
    acc_sh = acc_r >>> 8;
    if (acc_r <= 35'sd0)            mag = 8'd0;
    else if (acc_sh > 35'sd255)     mag = DRIVE_MAX;
    else                            mag = acc_sh[7:0];
    if (err_r > 16'sd0)             drive_nxt = $signed({1'b0, mag});
    else if (err_r < 16'sd0)        drive_nxt = -$signed({1'b0, mag});
    else                            drive_nxt = 9'sd0;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_r    <= wrap_idx[CH_W-1:0];
          tgt_r   <= in_target_speed;
          neg_r   <= in_pulse_count[31];
          pmag_r  <= pmag_in;
          div_r   <= in_elapsed_time;
          fault_r <= (in_elapsed_time == 32'd0);
        end
      end
      ST_MUL: begin
        quo_r <= spd_prod;
        rem_r <= 32'd0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        // shift one quotient bit in per cycle
        quo_r <= {quo_r[38:0], q_bit};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      ST_SPD: speed_r <= speed_nxt;
      ST_ERR: err_r   <= err_nxt;
      ST_SUM: begin
        sum_r  <= sum_nxt;
        diff_r <= diff_nxt;
        prod_r <= 33'sd0;
        acc_r  <= 35'sd0;
        gcnt_r <= 2'd0;
      end
      ST_GAIN: begin
        // product registered, accumulated on the next step
        prod_r <= mul_p;
        acc_r  <= acc_r + 35'(prod_r);
        gcnt_r <= gcnt_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        int_sum_r[i]  <= 15'd0;
        prev_err_r[i] <= 16'sd0;
        prev_tgt_r[i] <= 16'sd0;
      end
    end else if (state_r == ST_SUM) begin
      int_sum_r[ch_r]  <= sum_nxt;
      prev_err_r[ch_r] <= err_r;
      prev_tgt_r[ch_r] <= tgt_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: frees as soon as the result side takes the item
  // ---------------------------------------------------------------------
  logic signed [8:0]  drive_r;
  logic signed [15:0] o_speed_r;
  logic signed [15:0] o_err_r;
  logic               o_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drive_r   <= drive_nxt;
      o_speed_r <= speed_r;
      o_err_r   <= err_r;
      o_fault_r <= fault_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_level    = drive_r;
  assign out_measured_speed = o_speed_r;
  assign out_speed_error    = o_err_r;
  assign out_divide_fault   = o_fault_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "motor_speed_pid_step_assert.svh"

  `MSPS_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall, "input not held off after accept")
  `MSPS_ASSERT_NXT(a_sum_capped, state_r == ST_SUM, sum_r <= lim_r, "integral above limit")
  `MSPS_ASSERT_IMP(a_fault_zero_speed, out_valid && out_divide_fault, out_measured_speed == 16'sd0, "fault with nonzero speed")
  `MSPS_ASSERT_IMP(a_zero_err_no_drive, out_valid && out_speed_error == 16'sd0, out_drive_level == 9'sd0, "drive without error")

endmodule

// ===== bench/motor_speed_pid_step_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the four-channel motor speed PID tick.
// Each accepted tick is run through an in-bench predictor that keeps its own
// copy of the gains, limit, scale and per-channel integral, last error and
// last target. The predicted drive, speed, error and fault flags are queued
// and compared field by field against every result taken off the out channel.
module motor_speed_pid_step_tb;
  import msps_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int END_SETTLE      = 60;   // a little over the block's result latency
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic [1:0]         motor;
    logic signed [15:0] target;
    logic signed [31:0] pulses;
    logic [31:0]        etime;
  } pid_tick_t;

  typedef struct packed {
    logic signed [8:0]  drive;
    logic signed [15:0] speed;
    logic signed [15:0] speed_err;
    logic               fault;
  } pid_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_motor_index;
  logic signed [15:0]    in_target_speed;
  logic signed [31:0]    in_pulse_count;
  logic [31:0]           in_elapsed_time;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [8:0]     out_drive_level;
  logic signed [15:0]    out_measured_speed;
  logic signed [15:0]    out_speed_error;
  logic                  out_divide_fault;

  // Shadow copy of the configuration registers, starting at reset values.
  logic signed [15:0] gain_p_m = RST_GAIN_P;
  logic signed [15:0] gain_i_m = RST_GAIN_I;
  logic signed [15:0] gain_d_m = RST_GAIN_D;
  logic [14:0]        limit_m  = RST_INT_LIMIT;
  logic [7:0]         scale_m  = RST_SPEED_SCALE;

  // Shadow copy of the per-channel controller state, all zero out of reset.
  logic [14:0]        err_sum_m  [MSPS_MOTOR_COUNT] = '{default: '0};
  logic signed [15:0] last_err_m [MSPS_MOTOR_COUNT] = '{default: '0};
  logic signed [15:0] last_tgt_m [MSPS_MOTOR_COUNT] = '{default: '0};

  pid_result_t pending_results[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int hold_off_req   = 0;

  motor_speed_pid_step dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("motor_speed_pid_step verification failed");
      $finish;
    end
  end

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advance the shadow state by one tick and return what the block must produce.
  function automatic pid_result_t compute_pid_tick(pid_tick_t t);
    pid_result_t r;
    int          ch;
    longint      speed, err, total, diff, acc, mag, drive;
    ch = t.motor % MSPS_MOTOR_COUNT;
    r.fault = (t.etime == 0);
    // Zero time forces speed to 0; otherwise divide the exact product and
    // truncate toward zero before saturating.
    if (r.fault) speed = 0;
    else speed = clamp16((longint'(t.pulses) * longint'(scale_m)) / longint'(t.etime));
    err = clamp16(longint'(t.target) - speed);
    // A new target restarts the integral.
    if (t.target != last_tgt_m[ch]) err_sum_m[ch] = '0;
    total = longint'(err_sum_m[ch]) + ((err < 0) ? -err : err);
    if (total > longint'(limit_m)) total = longint'(limit_m);
    err_sum_m[ch] = total[14:0];
    // Derivative uses the full 17-bit difference, no saturation.
    diff = err - longint'(last_err_m[ch]);
    last_err_m[ch] = err[15:0];
    last_tgt_m[ch] = t.target;
    acc = longint'(gain_p_m) * err + longint'(gain_i_m) * total
        + longint'(gain_d_m) * diff;
    // Drop the fraction and clamp the magnitude to 0..255.
    if (acc <= 0) mag = 0;
    else begin
      mag = acc / 256;
      if (mag > 255) mag = 255;
    end
    if (err > 0) drive = mag;
    else if (err < 0) drive = -mag;
    else drive = 0;
    r.drive     = drive[8:0];
    r.speed     = speed[15:0];
    r.speed_err = err[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // Write all five registers back to back; hold the write enable high across
  // them and update the shadow copy at each write edge.
  task automatic write_config(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                              logic [15:0] lim, logic [15:0] scale);
    msps_cfg_t   order [5];
    logic [15:0] vals  [5];
    int          i;
    order = '{CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_INT_LIMIT, CFG_SPEED_SCALE};
    vals  = '{kp, ki, kd, lim, scale};
    cfg_we <= 1'b1;
    for (i = 0; i < 5; i++) begin
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      case (order[i])
        CFG_GAIN_P:      gain_p_m = vals[i];
        CFG_GAIN_I:      gain_i_m = vals[i];
        CFG_GAIN_D:      gain_d_m = vals[i];
        CFG_INT_LIMIT:   limit_m  = vals[i][14:0];
        CFG_SPEED_SCALE: scale_m  = vals[i][7:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one item, idling first at the current sender rate, and queue its
  // prediction at the edge that accepts it. Keep valid high between items.
  task automatic send_tick(pid_tick_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_motor_index  <= t.motor;
    in_target_speed <= t.target;
    in_pulse_count  <= t.pulses;
    in_elapsed_time <= t.etime;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(compute_pid_tick(t));
  endtask

  task automatic send_fields(logic [1:0] m, logic signed [15:0] tg,
                             logic signed [31:0] p, logic [31:0] et);
    pid_tick_t t;
    t.motor  = m;
    t.target = tg;
    t.pulses = p;
    t.etime  = et;
    send_tick(t);
  endtask

  // Stop offering and hold until every queued result has come back.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic: a channel usually keeps its last target so the
  // integral builds up and hits the limit, with edge values mixed in.
  function automatic pid_tick_t random_tick();
    pid_tick_t t;
    int        roll;
    t.motor = 2'($urandom_range(3));
    roll = $urandom_range(99);
    if (roll < 55) t.target = last_tgt_m[t.motor];
    else if (roll < 65) t.target = 16'($urandom);
    else if (roll < 72) begin
      case ($urandom_range(3))
        0: t.target = 16'sh7FFF;
        1: t.target = 16'sh8000;
        2: t.target = 16'sh0000;
        default: t.target = -16'sd1;
      endcase
    end else t.target = 16'($urandom_range(800) - 400);
    roll = $urandom_range(99);
    if (roll < 10) t.pulses = 32'($urandom);
    else if (roll < 16) begin
      case ($urandom_range(3))
        0: t.pulses = 32'sh7FFF_FFFF;
        1: t.pulses = 32'sh8000_0000;
        2: t.pulses = 32'sh0000_0000;
        default: t.pulses = -32'sd1;
      endcase
    end else t.pulses = 32'($urandom_range(4000) - 2000);
    roll = $urandom_range(99);
    if (roll < 5) t.etime = 32'd0;
    else if (roll < 12) t.etime = $urandom;
    else if (roll < 16) t.etime = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
    else t.etime = $urandom_range(3000, 50);
    return t;
  endfunction

  task automatic run_random_phase(int count);
    logic [15:0] kp, ki, kd, lim;
    kp  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1280) - 256);
    ki  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(192) - 64);
    kd  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512) - 256);
    lim = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2000));
    write_config(kp, ki, kd, lim, 16'($urandom));
    repeat (count) send_tick(random_tick());
    wait_drained();
  endtask

  // Measurement corners under reset gains: zero time, both saturations,
  // truncation toward zero, a zero error and every channel.
  task automatic test_measurement_edges();
    send_fields(2'd0, 16'sd100, 32'sd0, 32'd1);
    send_fields(2'd0, 16'sd100, 32'sd10, 32'd0);
    send_fields(2'd1, 16'sh7FFF, 32'sh8000_0000, 32'd1);
    send_fields(2'd2, 16'sh8000, 32'sh7FFF_FFFF, 32'd1);
    send_fields(2'd3, 16'sd0, -32'sd1000, 32'hFFFF_FFFF);
    send_fields(2'd3, 16'sd0, 32'sd7, 32'd3);
    send_fields(2'd1, -16'sd5, -32'sd3, 32'd7);
    send_fields(2'd2, 16'sd0, 32'sd0, 32'd1);
    send_fields(2'd0, -16'sd1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Build up the integral on one channel, then lower the limit under the
  // stored sum and change the target to clear it.
  task automatic test_integral_and_limit();
    write_config(16'sd256, 16'sd64, 16'sd128, 16'd1000, 16'd75);
    repeat (4) send_fields(2'd2, 16'sd200, 32'sd0, 32'd10);
    wait_drained();
    write_config(16'sd256, 16'sd64, 16'sd128, 16'd100, 16'd75);
    send_fields(2'd2, 16'sd200, 32'sd0, 32'd10);
    send_fields(2'd2, 16'sd201, 32'sd0, 32'd10);
    send_fields(2'd2, -16'sd300, 32'sd150, 32'd10);
    wait_drained();
  endtask

  // Negative gain: a positive error gives a negative sum and zero drive.
  task automatic test_negative_gain();
    write_config(-16'sd256, 16'sd0, 16'sd0, 16'd150, 16'd75);
    send_fields(2'd1, 16'sd500, 32'sd0, 32'd5);
    send_fields(2'd1, -16'sd500, 32'sd0, 32'd5);
    wait_drained();
  endtask

  // Register extremes, including data bits above the limit and scale widths.
  task automatic test_register_extremes();
    write_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h00FF);
    repeat (20) send_tick(random_tick());
    wait_drained();
    write_config(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    repeat (20) send_tick(random_tick());
    wait_drained();
    write_config(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFF01);
    repeat (20) send_tick(random_tick());
    wait_drained();
  endtask

  // Hold the result side off for a long stretch while items keep coming, so
  // the block fills and stalls its input.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (8) send_tick(random_tick());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    tx_idle_pct = 32;
    rx_idle_pct = 86;
    repeat (2) run_random_phase(300);
    tx_idle_pct = 86;
    rx_idle_pct = 32;
    repeat (2) run_random_phase(300);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (2) run_random_phase(250);
  endtask

  // Result-side stall: a requested hold-off wins, otherwise stall at random.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    pid_result_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, drive_level", out_drive_level, 0);
      end else begin
        head = pending_results.pop_front();
        if (out_drive_level !== head.drive)
          report_mismatch("drive_level", out_drive_level, head.drive);
        if (out_measured_speed !== head.speed)
          report_mismatch("measured_speed", out_measured_speed, head.speed);
        if (out_speed_error !== head.speed_err)
          report_mismatch("speed_error", out_speed_error, head.speed_err);
        if (out_divide_fault !== head.fault)
          report_mismatch("divide_fault", out_divide_fault, head.fault);
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_GAIN_P;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_motor_index  = '0;
    in_target_speed = '0;
    in_pulse_count  = '0;
    in_elapsed_time = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_measurement_edges();
    test_integral_and_limit();
    test_negative_gain();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    // Let any stray result show up before the verdict.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("motor_speed_pid_step verification clean");
    end else begin
      $display("motor_speed_pid_step verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/msps_pkg.sv
rtl/motor_speed_pid_step.sv
bench/motor_speed_pid_step_tb.sv
